// File: hw/rtl/sspp_pkg.sv
// Shared types, widths and codes for the stepper step pulse pacer.
package sspp_pkg;

    // Default tick rate of the timestamp (ticks per second)
    localparam int TICKS_PER_SECOND_DEF = 1000000;

    // Field widths
    localparam int FRAC_W   = 7;
    localparam int SPEED_W  = 10;
    localparam int DIR_W    = 2;
    localparam int NOW_W    = 32;
    localparam int PERIOD_W = 17;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    // Divisor is speed shifted by up to six places (fraction 64)
    localparam int SHAMT_W  = 3;
    localparam int DVS_W    = SPEED_W + 6;

    // Stream payload layout
    localparam int IN_FIELDS_W  = 1 + DIR_W + NOW_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 5 + PERIOD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 1'b1;

    // Supported microstep fractions
    localparam logic [FRAC_W-1:0] FRAC_8  = 7'd8;
    localparam logic [FRAC_W-1:0] FRAC_16 = 7'd16;
    localparam logic [FRAC_W-1:0] FRAC_32 = 7'd32;
    localparam logic [FRAC_W-1:0] FRAC_64 = 7'd64;

    // Direction codes (any other code keeps the pin)
    localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CCW = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOAD
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic item_take;
        logic div_start;
        logic div_step;
        logic period_load;
        logic period_clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic cfg_hit;
        logic cfg_zero;
    } t_status;

endpackage

// File: hw/rtl/stepper_step_pulse_pacer.sv
// Top level of the stepper step pulse pacer: controller plus datapath.
//
//  Channel   | Direction | Payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | run, direction, now_us (one move call per item)
//  m_axis    | out       | step_pulse, direction_level, enable_level, mode pins,
//            |           | step_period_us (one result per item)
//  cfg       | in        | write of microstep_fraction (0) or speed_rps (1)
//
//  The result of an item shows in m_axis the cycle after accept,
//  and the next item is taken while that result drains.
//  A write that leaves a supported fraction and a nonzero speed starts a
//  restoring divide, one quotient bit a cycle: s_axis is held through the
//  divide and the period load that follows it.
//  Reset is synchronous and active low; there is no clearing pass.
//  A stalled m_axis holds its result and blocks s_axis once full.
module stepper_step_pulse_pacer #(
    parameter int TICKS_PER_SECOND = sspp_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Move call input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] run, [2:1] direction, [34:3] now_us, [39:35] zero
    input  logic [sspp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Pin state output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] step_pulse, [1] direction_level, [2] enable_level, [3] mode_pin_zero,
    // [4] mode_pin_one, [21:5] step_period_us, [23:22] zero
    output logic [sspp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [sspp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sspp_pkg::CFG_W-1:0]       i_cfg_wdata
);

    sspp_pkg::t_cmd    cmd;
    sspp_pkg::t_status status;

    sspp_ctrl #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sspp_dpath #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// File: hw/rtl/sspp_ctrl.sv
// Controller: item handshake, output valid and the period divide sequence.
module sspp_ctrl #(
    parameter int TICKS_PER_SECOND = sspp_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sspp_pkg::t_status i_status,
    output sspp_pkg::t_cmd   o_cmd
);

    localparam int QW = $clog2(TICKS_PER_SECOND + 1);
    localparam int CW = $clog2(QW);

    sspp_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic             take;

    // Accept an item when idle and the output register is free or draining
    assign o_in_ready  = (r_state == sspp_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // State, counter and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sspp_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state            = r_state;
        n_count            = r_count;
        o_cmd              = '0;
        o_cmd.item_take    = take;

        if (take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        if (i_status.cfg_hit) begin
            // Restart from the new settings; zero speed needs no divide
            n_count = '0;
            if (i_status.cfg_zero) begin
                o_cmd.period_clear = 1'b1;
                n_state            = sspp_pkg::ST_IDLE;
            end else begin
                o_cmd.div_start = 1'b1;
                n_state         = sspp_pkg::ST_DIVIDE;
            end
        end else begin
            case (r_state)
                sspp_pkg::ST_IDLE: begin
                end
                sspp_pkg::ST_DIVIDE: begin
                    o_cmd.div_step = 1'b1;
                    n_count        = r_count + 1'b1;
                    if (r_count == CW'(QW - 1)) begin
                        n_state = sspp_pkg::ST_LOAD;
                    end
                end
                sspp_pkg::ST_LOAD: begin
                    o_cmd.period_load = 1'b1;
                    n_state           = sspp_pkg::ST_IDLE;
                end
                default: begin
                    n_state = sspp_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/sspp_dpath.sv
// Datapath: settings, pin state, period divider, step compare and result register.
module sspp_dpath #(
    parameter int TICKS_PER_SECOND = sspp_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sspp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sspp_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [sspp_pkg::IN_TDATA_W-1:0]     i_in_data,
    output logic [sspp_pkg::OUT_TDATA_W-1:0]    o_out_data,
    input  sspp_pkg::t_cmd                      i_cmd,
    output sspp_pkg::t_status                   o_status
);

    localparam int QW   = $clog2(TICKS_PER_SECOND + 1);
    localparam int WW   = (QW > sspp_pkg::PERIOD_W) ? QW : sspp_pkg::PERIOD_W;
    localparam int DVW  = sspp_pkg::DVS_W;
    localparam int PAD  = sspp_pkg::OUT_TDATA_W - sspp_pkg::OUT_FIELDS_W;
    localparam int NOWW = sspp_pkg::NOW_W;

    // Settings and pin state
    logic [sspp_pkg::FRAC_W-1:0]   r_frac, n_frac;
    logic [sspp_pkg::SPEED_W-1:0]  r_speed, n_speed;
    logic [1:0]                    r_pins;
    logic [sspp_pkg::PERIOD_W-1:0] r_period;
    logic [NOWW-1:0]               r_last;
    logic                          r_dir;

    // Divider registers
    logic [DVW-1:0] r_dvs;
    logic [DVW-1:0] r_rem, n_rem;
    logic [QW-1:0]  r_quo, n_quo;
    logic [DVW:0]   shifted;

    // Result register
    logic [sspp_pkg::OUT_TDATA_W-1:0] r_out;

    logic                          sup;
    logic [sspp_pkg::SHAMT_W-1:0]  shamt;
    logic [1:0]                    pins;
    logic [sspp_pkg::PERIOD_W-1:0] sat_quo;

    logic                    in_run;
    logic [sspp_pkg::DIR_W-1:0] in_dir;
    logic [NOWW-1:0]         in_now;
    logic [NOWW-1:0]         elapsed;
    logic                    pulse;
    logic                    n_dir;

    // Settings as they stand after this cycle's write
    always_comb begin
        n_frac  = r_frac;
        n_speed = r_speed;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sspp_pkg::CFG_FRACTION: n_frac  = i_cfg_wdata[sspp_pkg::FRAC_W-1:0];
                sspp_pkg::CFG_SPEED:    n_speed = i_cfg_wdata[sspp_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Decode fraction into mode pins and divisor shift
    always_comb begin
        sup   = 1'b1;
        shamt = '0;
        pins  = 2'b00;
        case (n_frac)
            sspp_pkg::FRAC_8: begin
                shamt = 3'd3;
                pins  = 2'b00;
            end
            sspp_pkg::FRAC_16: begin
                shamt = 3'd4;
                pins  = 2'b11;
            end
            sspp_pkg::FRAC_32: begin
                shamt = 3'd5;
                pins  = 2'b10;
            end
            sspp_pkg::FRAC_64: begin
                shamt = 3'd6;
                pins  = 2'b01;
            end
            default: begin
                sup = 1'b0;
            end
        endcase
    end

    assign o_status.cfg_hit  = i_cfg_we && sup;
    assign o_status.cfg_zero = (n_speed == '0);

    // One restoring divide step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_quo[QW-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = DVW'(shifted - {1'b0, r_dvs});
            n_quo = {r_quo[QW-2:0], 1'b1};
        end else begin
            n_rem = shifted[DVW-1:0];
            n_quo = {r_quo[QW-2:0], 1'b0};
        end
    end

    // Clamp the quotient to the period range
    always_comb begin
        if (WW'(r_quo) > WW'(sspp_pkg::PERIOD_MAX)) begin
            sat_quo = sspp_pkg::PERIOD_MAX;
        end else begin
            sat_quo = sspp_pkg::PERIOD_W'(r_quo);
        end
    end

    // Unpack the item and test the elapsed time against the period
    assign in_run  = i_in_data[0];
    assign in_dir  = i_in_data[sspp_pkg::DIR_W:1];
    assign in_now  = i_in_data[sspp_pkg::DIR_W+NOWW:sspp_pkg::DIR_W+1];
    assign elapsed = in_now - r_last;
    assign pulse   = in_run && (elapsed >= NOWW'(r_period));

    always_comb begin
        case (in_dir)
            sspp_pkg::DIR_CW:  n_dir = 1'b0;
            sspp_pkg::DIR_CCW: n_dir = 1'b1;
            default:           n_dir = r_dir;
        endcase
    end

    // Control state: settings, pins, period, direction, last step time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac   <= sspp_pkg::FRAC_8;
            r_speed  <= '0;
            r_pins   <= 2'b00;
            r_period <= '0;
            r_last   <= '0;
            r_dir    <= 1'b0;
        end else begin
            r_frac  <= n_frac;
            r_speed <= n_speed;
            if (o_status.cfg_hit) begin
                r_pins <= pins;
            end
            if (i_cmd.period_clear) begin
                r_period <= '0;
            end else if (i_cmd.period_load) begin
                r_period <= sat_quo;
            end
            if (i_cmd.item_take) begin
                r_dir <= n_dir;
                if (pulse) begin
                    r_last <= in_now;
                end
            end
        end
    end

    // Divider operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvs <= DVW'(n_speed) << shamt;
            r_rem <= '0;
            r_quo <= QW'(TICKS_PER_SECOND);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Capture the result of each item; every call leaves the driver enabled
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_take) begin
            r_out <= {{PAD{1'b0}}, r_period, r_pins[1], r_pins[0], 1'b0, n_dir, pulse};
        end
    end

    assign o_out_data = r_out;

endmodule

// File: hw/rtl/sspp_checker.sv
// Port-level checks for the stepper step pulse pacer, bound to the top level.
module sspp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [sspp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sspp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             i_cfg_we,
    input logic [sspp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [sspp_pkg::CFG_W-1:0]       i_cfg_wdata
);

    // No result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Every accepted item shows its result on the next cycle
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // An item without run never steps
    a_no_run_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tdata[0] |=> !m_axis_tdata[0])
        else $error("step issued without run");

    // Driver is enabled in every result
    a_enable_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[2])
        else $error("enable pin not active in result");

endmodule

bind stepper_step_pulse_pacer sspp_checker u_sspp_checker (.*);

// File: dv/tb.sv
// Testbench for the stepper step pulse pacer: directed, back-pressure and random move calls.
`timescale 1ns / 100ps

module tb;
    import sspp_pkg::*;

    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          RANDOM_CALLS  = 2000;
    localparam logic [DIR_W-1:0] DIR_KEEP     = 2'd0;
    localparam logic [DIR_W-1:0] DIR_KEEP_ALT = 2'd3;
    localparam longint unsigned  TICK_RATE    = TICKS_PER_SECOND_DEF;

    // Pin state of one move call, laid out as in m_axis_tdata
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                mode_one;
        logic                mode_zero;
        logic                enable;
        logic                dir;
        logic                pulse;
    } t_pin_state;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] run, [2:1] direction, [34:3] now_us, [39:35] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] step_pulse, [1] direction_level, [2] enable_level, [3] mode_pin_zero,
    // [4] mode_pin_one, [21:5] step_period_us, [23:22] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    // Predicted block state and register copies
    logic [FRAC_W-1:0]   cfg_fraction;
    logic [SPEED_W-1:0]  cfg_speed;
    logic [NOW_W-1:0]    pace_last_step;
    logic                pace_dir;
    logic                pace_enable;
    logic [1:0]          pace_pins;
    logic [PERIOD_W-1:0] pace_period;

    t_pin_state          pin_state_due[$];
    logic [NOW_W-1:0]    stamp_cursor = '0;
    bit                  sender_free = 1'b0;
    bit                  receiver_free = 1'b0;
    int                  hold_request = 0;
    int                  mismatch_count = 0;
    int                  moves_sent = 0;
    int                  pulses_seen = 0;
    int                  reg_writes = 0;
    int                  cycle_count = 0;

    stepper_step_pulse_pacer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[stepper_step_pulse_pacer] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reset_pacing();
        cfg_fraction   = FRAC_8;
        cfg_speed      = '0;
        pace_last_step = '0;
        pace_dir       = 1'b0;
        pace_enable    = 1'b1;
        pace_pins      = 2'b00;
        pace_period    = '0;
    endfunction

    // Re-derive mode pins and step period from both registers
    function automatic void retune_pacing();
        logic [1:0]      pins;
        longint unsigned prod;
        longint unsigned quot;
        case (cfg_fraction)
            FRAC_8:  pins = 2'b00;
            FRAC_16: pins = 2'b11;
            FRAC_32: pins = 2'b10;
            FRAC_64: pins = 2'b01;
            default: return;
        endcase
        pace_pins = pins;
        if (cfg_speed == '0) begin
            pace_period = '0;
        end else begin
            prod = cfg_fraction * cfg_speed;
            quot = TICK_RATE / prod;
            pace_period = (quot > PERIOD_MAX) ? PERIOD_MAX : quot[PERIOD_W-1:0];
        end
    endfunction

    // Pin state after one move call
    function automatic t_pin_state predict_move_call(logic run, logic [DIR_W-1:0] dir,
                                                     logic [NOW_W-1:0] now);
        t_pin_state       res;
        logic [NOW_W-1:0] elapsed;
        pace_enable = 1'b0;
        if (dir == DIR_CW) begin
            pace_dir = 1'b0;
        end else if (dir == DIR_CCW) begin
            pace_dir = 1'b1;
        end
        elapsed   = now - pace_last_step;
        res.pulse = 1'b0;
        if (run && elapsed >= NOW_W'(pace_period)) begin
            res.pulse      = 1'b1;
            pace_last_step = now;
        end
        res.dir       = pace_dir;
        res.enable    = pace_enable;
        res.mode_zero = pace_pins[0];
        res.mode_one  = pace_pins[1];
        res.period    = pace_period;
        return res;
    endfunction

    // Timestamps near the pacing boundary, across the wrap, and far jumps
    function automatic logic [NOW_W-1:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            stamp_cursor += $urandom_range(0, 2 * pace_period + 2);
        end else if (r < 80) begin
            stamp_cursor = pace_last_step + pace_period - $urandom_range(0, 1);
        end else if (r < 90) begin
            stamp_cursor = $urandom;
        end else begin
            stamp_cursor = '1 - $urandom_range(0, pace_period + 3);
        end
        return stamp_cursor;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver: random stalls, stall-free stretches, and requested hold-offs
    initial begin : receiver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (!receiver_free && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_pin_state got;
        t_pin_state want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (pin_state_due.size() == 0) begin
                $error("unexpected result 0x%h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pin_state_due.pop_front();
                check_field("step_pulse", want.pulse, got.pulse);
                check_field("direction_level", want.dir, got.dir);
                check_field("enable_level", want.enable, got.enable);
                check_field("mode_pin_zero", want.mode_zero, got.mode_zero);
                check_field("mode_pin_one", want.mode_one, got.mode_one);
                check_field("step_period_us", want.period, got.period);
                if (got.pulse) pulses_seen++;
            end
        end
    end

    // Offer one move call, predict it on accept, then maybe idle
    task automatic send_move(input logic run, input logic [DIR_W-1:0] dir,
                             input logic [NOW_W-1:0] now);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, now, dir, run};
        do @(posedge i_clk); while (!s_axis_tready);
        pin_state_due.push_back(predict_move_call(run, dir, now));
        moves_sent++;
        gap = sender_free ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait for every pending result
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pin_state_due.size() != 0 || m_axis_tvalid) @(posedge i_clk);
    endtask

    // Write a register while idle, then wait out any period recompute
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FRACTION: cfg_fraction = value[FRAC_W-1:0];
            CFG_SPEED:    cfg_speed    = value[SPEED_W-1:0];
            default:      ;
        endcase
        retune_pacing();
        reg_writes++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Step right below and right at the period
    task automatic send_boundary_pair(input logic [DIR_W-1:0] dir);
        send_move(1'b1, dir, pace_last_step + pace_period - 1);
        send_move(1'b1, dir, pace_last_step + pace_period);
    endtask

    task automatic test_directed();
        // Reset pacing: zero period, every direction code
        send_move(1'b0, DIR_KEEP, '0);
        send_move(1'b1, DIR_CCW, '0);
        send_move(1'b1, DIR_KEEP_ALT, '1);
        send_move(1'b0, DIR_CW, 32'd5);
        // Longest period, then timestamp behind the last step and run held low
        write_reg(CFG_FRACTION, CFG_W'(FRAC_8));
        write_reg(CFG_SPEED, 10'd1);
        send_boundary_pair(DIR_CCW);
        send_move(1'b1, DIR_KEEP, pace_last_step - 1);
        send_move(1'b0, DIR_CW, pace_last_step + 32'd200000);
        // Shortest period
        write_reg(CFG_FRACTION, CFG_W'(FRAC_64));
        write_reg(CFG_SPEED, 10'd1023);
        send_boundary_pair(DIR_KEEP_ALT);
        // Upper write bits beyond the fraction width are dropped
        write_reg(CFG_FRACTION, 10'h390);
        send_move(1'b1, DIR_CCW, '1);
        write_reg(CFG_FRACTION, CFG_W'(FRAC_32));
        send_move(1'b1, DIR_CW, 32'h8000_0000);
        // Unsupported fractions leave pins and period as they were
        write_reg(CFG_FRACTION, 10'd127);
        write_reg(CFG_SPEED, 10'd3);
        send_move(1'b1, DIR_KEEP, 32'h7FFF_FFFF);
        write_reg(CFG_FRACTION, 10'd0);
        send_move(1'b1, DIR_CCW, 32'h0000_FFFF);
        // Zero speed: every run call steps
        write_reg(CFG_FRACTION, CFG_W'(FRAC_8));
        write_reg(CFG_SPEED, 10'd0);
        send_move(1'b1, DIR_CW, pace_last_step);
        send_move(1'b1, DIR_CW, pace_last_step);
    endtask

    // Hold the receiver off while the sender keeps offering
    task automatic test_backpressure();
        write_reg(CFG_FRACTION, CFG_W'(FRAC_16));
        write_reg(CFG_SPEED, 10'd25);
        sender_free  = 1'b1;
        hold_request = 300;
        repeat (40) begin
            send_move(1'($urandom_range(0, 1)), DIR_W'($urandom_range(0, 3)), pick_stamp());
        end
        sender_free = 1'b0;
        drain_results();
    endtask

    task automatic test_random();
        int         sent;
        int         phase_len;
        int         r;
        logic [CFG_W-1:0] frac_word;
        logic [CFG_W-1:0] speed_word;
        sent = 0;
        while (sent < RANDOM_CALLS) begin
            // Pick new settings, mostly supported fractions
            r = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0: frac_word = CFG_W'(FRAC_8);
                1: frac_word = CFG_W'(FRAC_16);
                2: frac_word = CFG_W'(FRAC_32);
                default: frac_word = CFG_W'(FRAC_64);
            endcase
            if (r < 2) frac_word = CFG_W'($urandom_range(0, 1023));
            else if (r == 2) frac_word[CFG_W-1:FRAC_W] = (CFG_W-FRAC_W)'($urandom);
            r = $urandom_range(0, 9);
            if (r == 0) speed_word = '0;
            else if (r == 1) speed_word = '1;
            else if (r < 4) speed_word = CFG_W'($urandom_range(1, 4));
            else speed_word = CFG_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 5) != 0) write_reg(CFG_FRACTION, frac_word);
            write_reg(CFG_SPEED, speed_word);
            sender_free   = ($urandom_range(0, 3) == 0);
            receiver_free = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(100, 250);
            repeat (phase_len) begin
                send_move($urandom_range(0, 99) < 85, DIR_W'($urandom_range(0, 3)),
                          pick_stamp());
            end
            sent += phase_len;
        end
        sender_free   = 1'b0;
        receiver_free = 1'b0;
        drain_results();
    endtask

    initial begin
        reset_pacing();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pin_state_due.size() != 0) begin
            $error("%0d results never arrived", pin_state_due.size());
            mismatch_count++;
        end
        $display("Run covered %0d move calls with %0d step pulses over %0d register writes,",
                 moves_sent, pulses_seen, reg_writes);
        $display("including period edges, timestamp wrap and a long output stall.");
        if (mismatch_count == 0) begin
            $display("[stepper_step_pulse_pacer] OK");
        end else begin
            $display("[stepper_step_pulse_pacer] ERROR");
        end
        $finish;
    end

endmodule
